// File: rtl/core/arat_pkg.sv
package arat_pkg;

    localparam int ROUTE_ENTRIES_DEF = 8;
    localparam int QUEUE_DEPTH       = 2;
    localparam int Q_PTR_W           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam int PEER_W = 48;
    localparam int ADDR_W = 32;
    localparam int TIME_W = 64;

    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_LOOKUP  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    localparam logic [7:0] PEER_HEAD = 8'h32;
    localparam logic [3:0] BCD_MAX   = 4'd9;

    typedef struct packed {
        logic              opcode;
        logic              drop;
        logic [PEER_W-1:0] peer;
        logic [ADDR_W-1:0] route_address;
        logic [TIME_W-1:0] now;
    } job_t;

    typedef struct packed {
        logic busy;
        logic scanning;
    } back_stat_t;

    function automatic logic nonzero_bcd(input logic [7:0] b);
        nonzero_bcd = (b != 8'h00) && (b[7:4] <= BCD_MAX) && (b[3:0] <= BCD_MAX);
    endfunction

    function automatic logic peer_ok(input logic [PEER_W-1:0] p);
        peer_ok = (p[47:40] == PEER_HEAD) && nonzero_bcd(p[39:32])
            && nonzero_bcd(p[31:24]) && (p[23:16] == 8'h00)
            && nonzero_bcd(p[15:8]) && (p[7:0] == 8'h00);
    endfunction

endpackage

// File: rtl/core/arat_front.sv
module arat_front (
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        opcode,
    input  logic [arat_pkg::PEER_W-1:0] peer,
    input  logic [arat_pkg::ADDR_W-1:0] route_address,
    input  logic [arat_pkg::TIME_W-1:0] now,
    input  logic                        is_reply,
    input  logic [arat_pkg::TIME_W-1:0] max_age,
    input  logic                        q_full,
    output logic                        q_push,
    output arat_pkg::job_t              q_job
);
    import arat_pkg::*;

    logic well_formed;
    logic drop;

    assign well_formed = peer_ok(peer);

    // items that can never touch the table skip the scan
    always_comb
    begin
        unique case (opcode)
            OP_OBSERVE: drop = !(is_reply && well_formed && (route_address != '0));
            OP_LOOKUP:  drop = !(well_formed && (max_age != '0));
            default:    drop = 1'b1;
        endcase
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_job.opcode        = opcode;
        q_job.drop          = drop;
        q_job.peer          = peer;
        q_job.route_address = route_address;
        q_job.now           = now;
    end

endmodule

// File: rtl/core/arat_queue.sv
module arat_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  arat_pkg::job_t               push_job,
    input  logic                         pop,
    output arat_pkg::job_t               pop_job,
    output logic                         full,
    output logic                         not_empty,
    output logic [arat_pkg::Q_CNT_W-1:0] count
);
    import arat_pkg::*;

    job_t               slot_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;
    assign pop_job   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/core/arat_back.sv
module arat_back #(
    parameter int ROUTE_ENTRIES = arat_pkg::ROUTE_ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_not_empty,
    input  arat_pkg::job_t              q_job,
    output logic                        q_pop,
    input  logic [arat_pkg::TIME_W-1:0] max_age,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        status,
    output logic [arat_pkg::ADDR_W-1:0] found_address,
    output arat_pkg::back_stat_t        stat
);
    import arat_pkg::*;

    localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUTE_ENTRIES - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [PEER_W-1:0] peer_mem [ROUTE_ENTRIES];
    logic [ADDR_W-1:0] addr_mem [ROUTE_ENTRIES];
    logic [TIME_W-1:0] time_mem [ROUTE_ENTRIES];

    logic [2:0]               state_reg, state_next;
    job_t                     job_reg, job_next;
    logic [IDX_W-1:0]         scan_idx_reg, scan_idx_next;
    logic                     issue_done_reg, issue_done_next;
    logic                     cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]         cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]         hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]         ptr_reg, ptr_next;
    logic [ROUTE_ENTRIES-1:0] valid_reg, valid_next;
    logic                     res_status_reg, res_status_next;
    logic [ADDR_W-1:0]        res_found_reg, res_found_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_status_reg, out_status_next;
    logic [ADDR_W-1:0]        out_found_reg, out_found_next;

    logic [PEER_W-1:0] rd_peer_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [TIME_W-1:0] rd_time_reg;

    logic [IDX_W-1:0]  rd_idx;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic              match;
    logic              newer;
    logic [TIME_W-1:0] age;

    assign rd_idx = (state_reg == S_SCAN) ? scan_idx_reg : hit_idx_reg;
    assign match  = cmp_vld_reg && valid_reg[cmp_idx_reg] && (rd_peer_reg == job_reg.peer);
    assign newer  = (job_reg.now >= rd_time_reg);
    assign age    = job_reg.now - rd_time_reg;

    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = scan_idx_reg;
        hit_idx_next    = hit_idx_reg;
        ptr_next        = ptr_reg;
        valid_next      = valid_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        q_pop           = 1'b0;
        wr_en           = 1'b0;
        wr_idx          = hit_idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop           = 1'b1;
                    job_next        = q_job;
                    res_status_next = STATUS_FAIL;
                    res_found_next  = '0;
                    scan_idx_next   = '0;
                    issue_done_next = 1'b0;
                    state_next      = q_job.drop ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    hit_idx_next = cmp_idx_reg;
                    state_next   = S_FETCH;
                end
                else if (cmp_vld_reg && (cmp_idx_reg == LAST_IDX))
                begin
                    // miss: observe takes the round-robin slot
                    if (job_reg.opcode == OP_OBSERVE)
                    begin
                        wr_en              = 1'b1;
                        wr_idx             = ptr_reg;
                        valid_next[ptr_reg] = 1'b1;
                        ptr_next           = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
                        res_status_next    = STATUS_OK;
                    end
                    state_next = S_DONE;
                end
                else if (!issue_done_reg)
                begin
                    cmp_vld_next = 1'b1;
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (job_reg.opcode == OP_OBSERVE)
                begin
                    if (newer)
                    begin
                        wr_en           = 1'b1;
                        res_status_next = STATUS_OK;
                    end
                end
                else if (newer && (age < max_age))
                begin
                    res_status_next = STATUS_OK;
                    res_found_next  = rd_addr_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_found_next  = res_found_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            issue_done_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            ptr_reg        <= '0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_done_reg <= issue_done_next;
            cmp_vld_reg    <= cmp_vld_next;
            ptr_reg        <= ptr_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg        <= job_next;
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_idx_reg    <= hit_idx_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            peer_mem[wr_idx] <= job_reg.peer;
            addr_mem[wr_idx] <= job_reg.route_address;
            time_mem[wr_idx] <= job_reg.now;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_peer_reg <= peer_mem[rd_idx];
        rd_addr_reg <= addr_mem[rd_idx];
        rd_time_reg <= time_mem[rd_idx];
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign found_address = out_found_reg;

    always_comb
    begin
        stat.busy     = (state_reg != S_IDLE);
        stat.scanning = (state_reg == S_SCAN);
    end

endmodule

// File: rtl/core/aged_address_route_table_core.sv
// Route table of up to ROUTE_ENTRIES station-address to IPv4 entries with ageing.
// Items pass a classifier into a two-beat queue; the back end then scans the
// peer memory one entry per cycle and writes back at most one entry. An item
// that cannot touch the table goes from the queue straight to S_DONE; others
// pass S_SCAN, and on a match S_FETCH and S_EVAL, before S_DONE. The scan goes
// serially through the single read port. One item is worked on at a time,
// while the queue and the output register keep both sides moving. The user must
// see that max_age is written only while the block is idle; it is not enforced.
module aged_address_route_table_core #(
    parameter int ROUTE_ENTRIES = arat_pkg::ROUTE_ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        max_age_we,
    input  logic [arat_pkg::TIME_W-1:0] max_age_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        opcode,
    input  logic [arat_pkg::PEER_W-1:0] peer,
    input  logic [arat_pkg::ADDR_W-1:0] route_address,
    input  logic [arat_pkg::TIME_W-1:0] now,
    input  logic                        is_reply,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        status,
    output logic [arat_pkg::ADDR_W-1:0] found_address
);
    import arat_pkg::*;

    logic [TIME_W-1:0]  max_age_reg;
    logic               q_push;
    job_t               push_job;
    logic               q_pop;
    job_t               pop_job;
    logic               q_full;
    logic               q_not_empty;
    logic [Q_CNT_W-1:0] q_count;
    back_stat_t         back_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_age_reg <= '0;
        end
        else if (max_age_we)
        begin
            max_age_reg <= max_age_wdata;
        end
    end

    arat_front u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .peer          (peer),
        .route_address (route_address),
        .now           (now),
        .is_reply      (is_reply),
        .max_age       (max_age_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (push_job)
    );

    arat_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .pop       (q_pop),
        .pop_job   (pop_job),
        .full      (q_full),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    arat_back #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_job         (pop_job),
        .q_pop         (q_pop),
        .max_age       (max_age_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .found_address (found_address),
        .stat          (back_stat)
    );

`ifndef SYNTHESIS
    a_fail_no_address: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_FAIL)) |-> (found_address == '0))
        else $error("failed result carries an address");

    a_idle_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (!back_stat.busy && q_not_empty) |=> back_stat.busy)
        else $error("back end left a queued beat waiting");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (q_count == Q_CNT_W'(QUEUE_DEPTH)))
        else $error("input stalled with room in the queue");
`endif

endmodule
